// ===== sv/temb_pkg.sv =====
// ----------------------------------------------------------------------------
// temb_pkg
// Types, codes and helper functions for the typed endian memory access block.
// ----------------------------------------------------------------------------
`default_nettype none

package temb_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_STORE = 1'b1;

    localparam logic [3:0] DT_LE1    = 4'd0;
    localparam logic [3:0] DT_BE1    = 4'd1;
    localparam logic [3:0] DT_BYTE   = 4'd2;
    localparam logic [3:0] DT_LE16   = 4'd3;
    localparam logic [3:0] DT_BE16   = 4'd4;
    localparam logic [3:0] DT_LE32   = 4'd5;
    localparam logic [3:0] DT_BE32   = 4'd6;
    localparam logic [3:0] DT_LE32R  = 4'd7;
    localparam logic [3:0] DT_BE32R  = 4'd8;
    localparam logic [3:0] DT_LE64   = 4'd9;
    localparam logic [3:0] DT_BE64   = 4'd10;
    localparam logic [3:0] DT_LE64R  = 4'd11;
    localparam logic [3:0] DT_BE64R  = 4'd12;
    localparam logic [3:0] DT_LE64R4 = 4'd13;
    localparam logic [3:0] DT_BE64R4 = 4'd14;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_CELL     = 2'd1;
    localparam logic [1:0] STAT_BIT      = 2'd2;
    localparam logic [1:0] STAT_CELLSIZE = 2'd3;

    localparam int LANES = 8;

    typedef enum logic [1:0] {
        SW_NONE,
        SW_H16,
        SW_R16,
        SW_R32
    } swap_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    typedef struct packed {
        logic        cmd;
        logic [3:0]  type_code;
        logic [11:0] cell_req;
        logic [5:0]  bit_index;
        logic [63:0] write_data;
    } req_t;

    typedef struct packed {
        logic       valid;
        logic       is_bit;
        logic [3:0] nbytes;
        logic [3:0] limit;
        logic       big;
        swap_t      mode;
    } access_t;

    function automatic access_t decode_type(input logic [3:0] t);
        access_t a;
        a = '{valid: 1'b1, is_bit: 1'b0, nbytes: 4'd1, limit: 4'd8,
              big: 1'b0, mode: SW_NONE};
        case (t)
            DT_LE1:    a.is_bit = 1'b1;
            DT_BE1:    begin a.is_bit = 1'b1; a.big = 1'b1; end
            DT_BYTE:   a.limit = 4'd1;
            DT_LE16:   begin a.nbytes = 4'd2; a.limit = 4'd2; end
            DT_BE16:   begin a.nbytes = 4'd2; a.limit = 4'd2; a.big = 1'b1; end
            DT_LE32:   begin a.nbytes = 4'd4; a.limit = 4'd4; end
            DT_BE32:   begin a.nbytes = 4'd4; a.limit = 4'd4; a.big = 1'b1; end
            DT_LE32R:  begin a.nbytes = 4'd4; a.limit = 4'd4; a.mode = SW_H16; end
            DT_BE32R:
            begin
                a.nbytes = 4'd4; a.limit = 4'd4; a.big = 1'b1; a.mode = SW_H16;
            end
            DT_LE64:   begin a.nbytes = 4'd8; a.limit = 4'd4; end
            DT_BE64:   begin a.nbytes = 4'd8; a.limit = 4'd4; a.big = 1'b1; end
            DT_LE64R:  begin a.nbytes = 4'd8; a.limit = 4'd4; a.mode = SW_R16; end
            DT_BE64R:
            begin
                a.nbytes = 4'd8; a.limit = 4'd4; a.big = 1'b1; a.mode = SW_R16;
            end
            DT_LE64R4: begin a.nbytes = 4'd8; a.limit = 4'd4; a.mode = SW_R32; end
            DT_BE64R4:
            begin
                a.nbytes = 4'd8; a.limit = 4'd4; a.big = 1'b1; a.mode = SW_R32;
            end
            default:   a.valid = 1'b0;
        endcase
        return a;
    endfunction

    function automatic logic [14:0] cell_addr(input logic [11:0] cell_idx,
                                              input logic [1:0] csc);
        return 15'({3'b000, cell_idx} << csc);
    endfunction

    function automatic logic [63:0] width_mask(input logic [3:0] n);
        logic [63:0] m;
        case (n)
            4'd1:    m = 64'h0000_0000_0000_00FF;
            4'd2:    m = 64'h0000_0000_0000_FFFF;
            4'd4:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = '1;
        endcase
        return m;
    endfunction

    // reverse the order of the low n bytes
    function automatic logic [63:0] byte_rev(input logic [63:0] v, input logic [3:0] n);
        logic [63:0] r;
        case (n)
            4'd1:    r = {56'd0, v[7:0]};
            4'd2:    r = {48'd0, v[7:0], v[15:8]};
            4'd4:    r = {32'd0, v[7:0], v[15:8], v[23:16], v[31:24]};
            default: r = {v[7:0], v[15:8], v[23:16], v[31:24],
                          v[39:32], v[47:40], v[55:48], v[63:56]};
        endcase
        return r;
    endfunction

    function automatic logic [63:0] word_swap(input logic [63:0] v, input swap_t mode);
        logic [63:0] r;
        case (mode)
            SW_H16:  r = {32'd0, v[15:0], v[31:16]};
            SW_R16:  r = {v[15:0], v[31:16], v[47:32], v[63:48]};
            SW_R32:  r = {v[31:0], v[63:32]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/temb_if.sv =====
// ----------------------------------------------------------------------------
// temb_if
// Request and response channels: valid/ready with payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface temb_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [3:0]  type_code;
    logic [11:0] cell_req;
    logic [5:0]  bit_index;
    logic [63:0] write_data;

    modport source (output valid, cmd, type_code, cell_req, bit_index, write_data,
                    input ready);
    modport sink   (input valid, cmd, type_code, cell_req, bit_index, write_data,
                    output ready);
endinterface

interface temb_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_data;
    logic [1:0]  status;

    modport source (output valid, read_data, status, input ready);
    modport sink   (input valid, read_data, status, output ready);
endinterface

`default_nettype wire

// ===== sv/typed_endian_memory_access.sv =====
// ----------------------------------------------------------------------------
// typed_endian_memory_access
// Byte-addressed store with typed, endian-aware loads and stores.
// ----------------------------------------------------------------------------
// Each request passes a read step, which reads the eight byte lanes of the
// store (each lane a RAM with registered read), and an execute step, which
// checks, reorders, modifies, writes back and loads the response register; it
// waits while the previous response is not yet taken. A bit store is handled
// in the same steps as a read-modify-write. A new request is taken while the
// previous response waits. After reset the store is cleared one row of eight
// bytes per cycle; no request is taken then, configuration writes throughout.
`default_nettype none

module typed_endian_memory_access
    import temb_pkg::*;
#(
    parameter int MEM_BYTES = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    temb_req_if.sink         req,
    temb_rsp_if.source       rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int ROWS  = (MEM_BYTES + LANES - 1) / LANES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    state_t      state_reg, state_next;
    logic [ROW_W-1:0] clr_cnt_reg;
    logic [1:0]  csc_reg;
    req_t        req_reg;
    logic        out_valid_reg;
    logic [63:0] read_data_reg;
    logic [1:0]  status_reg;

    logic        clearing;
    logic        accept;
    logic        exec_fire;
    logic        clr_last;

    logic [14:0] rd_addr;
    logic [14:0] wr_addr;
    logic [7:0][ROW_W-1:0] rd_row;
    logic [7:0][ROW_W-1:0] wr_row;
    logic [7:0][7:0] lane_rdata;
    logic [63:0] dp_read_data;
    logic [1:0]  dp_status;
    logic [7:0]  dp_wr_en;
    logic [7:0][7:0] dp_wr_byte;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {30'd0, csc_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            csc_reg <= 2'd0;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
        begin
            csc_reg <= pwdata[1:0];
        end
    end

    // control
    assign clr_last = (clr_cnt_reg == ROW_W'(ROWS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR: if (clr_last) state_next = S_IDLE;
            S_IDLE:  if (req.valid) state_next = S_EXEC;
            S_EXEC:  if (exec_fire) state_next = S_IDLE;
            default: state_next = S_CLEAR;
        endcase
    end

    always_comb
    begin
        clearing  = (state_reg == S_CLEAR);
        req.ready = (state_reg == S_IDLE);
        accept    = (state_reg == S_IDLE) && req.valid;
        exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || rsp.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
            end
            if (exec_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg.cmd        <= req.cmd;
            req_reg.type_code  <= req.type_code;
            req_reg.cell_req   <= req.cell_req;
            req_reg.bit_index  <= req.bit_index;
            req_reg.write_data <= req.write_data;
        end
        if (exec_fire)
        begin
            read_data_reg <= dp_read_data;
            status_reg    <= dp_status;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = read_data_reg;
    assign rsp.status    = status_reg;

    // lane rows: lanes below the start offset fall in the next row
    assign rd_addr = cell_addr(req.cell_req, csc_reg);
    assign wr_addr = cell_addr(req_reg.cell_req, csc_reg);

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rd_row[l] = ROW_W'(16'(rd_addr[14:3]) +
                               16'((3'(l) < rd_addr[2:0]) ? 1 : 0));
            wr_row[l] = ROW_W'(16'(wr_addr[14:3]) +
                               16'((3'(l) < wr_addr[2:0]) ? 1 : 0));
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        temb_bank #(
            .DEPTH (ROWS),
            .AW    (ROW_W)
        ) u_bank (
            .clk   (clk),
            .we    (clearing || (exec_fire && dp_wr_en[g])),
            .waddr (clearing ? clr_cnt_reg : wr_row[g]),
            .wdata (clearing ? 8'd0 : dp_wr_byte[g]),
            .re    (accept),
            .raddr (rd_row[g]),
            .rdata (lane_rdata[g])
        );
    end

    temb_datapath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_datapath (
        .req        (req_reg),
        .csc        (csc_reg),
        .lane_rdata (lane_rdata),
        .read_data  (dp_read_data),
        .status     (dp_status),
        .wr_en      (dp_wr_en),
        .wr_byte    (dp_wr_byte)
    );

endmodule

`default_nettype wire

// ===== sv/temb_bank.sv =====
// ----------------------------------------------------------------------------
// temb_bank
// One byte lane of the store: simple dual-port RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module temb_bank #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/temb_datapath.sv =====
// ----------------------------------------------------------------------------
// temb_datapath
// Access checks, lane gather, byte order and word swap, bit modify, scatter.
// ----------------------------------------------------------------------------
`default_nettype none

module temb_datapath
    import temb_pkg::*;
#(
    parameter int MEM_BYTES = 4096
) (
    input  wire req_t             req,
    input  wire logic [1:0]       csc,
    input  wire logic [7:0][7:0]  lane_rdata,
    output logic      [63:0]      read_data,
    output logic      [1:0]       status,
    output logic      [7:0]       wr_en,
    output logic      [7:0][7:0]  wr_byte
);

    access_t     acc;
    logic [3:0]  cs;
    logic [3:0]  n;
    logic [14:0] addr;
    logic [15:0] end_addr;
    logic [2:0]  off;
    logic        ok;
    logic [63:0] raw;
    logic [63:0] val;
    logic [63:0] newv;
    logic [63:0] wv;
    logic [2:0]  lane_k;

    always_comb
    begin
        acc      = decode_type(req.type_code);
        cs       = 4'(4'd1 << csc);
        n        = acc.is_bit ? cs : acc.nbytes;
        addr     = cell_addr(req.cell_req, csc);
        end_addr = 16'(addr) + 16'(n) - 16'd1;
        off      = addr[2:0];

        if (!acc.valid)
        begin
            status = STAT_CELLSIZE;
        end
        else if (acc.is_bit)
        begin
            if (32'(end_addr) >= MEM_BYTES)
            begin
                status = STAT_CELL;
            end
            else if (7'(req.bit_index) >= 7'({cs, 3'b000}))
            begin
                status = STAT_BIT;
            end
            else
            begin
                status = STAT_OK;
            end
        end
        else if (cs > acc.limit)
        begin
            status = STAT_CELLSIZE;
        end
        else if (32'(end_addr) >= MEM_BYTES)
        begin
            status = STAT_CELL;
        end
        else
        begin
            status = STAT_OK;
        end
        ok = (status == STAT_OK);

        for (int k = 0; k < LANES; k++)
        begin
            raw[8*k +: 8] = (4'(k) < n) ? lane_rdata[off + 3'(k)] : 8'd0;
        end
        val = acc.big ? byte_rev(raw, n) : raw;

        if (acc.is_bit)
        begin
            newv = val & ~(64'd1 << req.bit_index);
            if (req.write_data != 64'd0)
            begin
                newv = newv | (64'd1 << req.bit_index);
            end
        end
        else
        begin
            newv = word_swap(req.write_data & width_mask(n), acc.mode);
        end
        wv = acc.big ? byte_rev(newv, n) : newv;

        // byte position of each lane within the access, modulo the row
        lane_k = 3'd0;
        for (int l = 0; l < LANES; l++)
        begin
            lane_k     = 3'(l) - off;
            wr_en[l]   = (req.cmd == CMD_STORE) && ok && ({1'b0, lane_k} < n);
            wr_byte[l] = wv[{lane_k, 3'b000} +: 8];
        end

        if (req.cmd == CMD_STORE || !ok)
        begin
            read_data = 64'd0;
        end
        else if (acc.is_bit)
        begin
            read_data = {63'd0, val[req.bit_index]};
        end
        else
        begin
            read_data = word_swap(val, acc.mode);
        end
    end

endmodule

`default_nettype wire

// ===== sv/temb_checker.sv =====
// ----------------------------------------------------------------------------
// temb_checker
// Port-level checks on the typed endian memory access block.
// ----------------------------------------------------------------------------
`default_nettype none

module temb_checker
    import temb_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_ready,
    input wire logic        rsp_valid,
    input wire logic        rsp_ready,
    input wire logic [63:0] rsp_read_data,
    input wire logic [1:0]  rsp_status,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata
);

    // a stalled response beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data)
                                    && $stable(rsp_status))
        else $error("response changed while stalled");

    // one request in flight: no request taken in the cycle after one is taken
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in flight");

    // failed access reads zero
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STAT_OK |-> rsp_read_data == 64'd0)
        else $error("nonzero read data on failed access");

    // cell size register reads back what was written
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == 1'b0
        |=> paddr[2] || prdata[1:0] == $past(pwdata[1:0]))
        else $error("cell size register read-back mismatch");

endmodule

bind typed_endian_memory_access temb_checker u_temb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_read_data (rsp.read_data),
    .rsp_status    (rsp.status),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);

`default_nettype wire
